// ----- design/sle_pkg.sv -----
// shared types, character codes and six-bit helper for the serial line packet encoder
package sle_pkg;

    // character codes
    localparam logic [7:0] NL_CHAR    = 8'h0A;
    localparam logic [7:0] BSL_CHAR   = 8'h5C;
    localparam logic [7:0] BRACE_CHAR = 8'h7D;

    // line mode codes (mode three behaves as six-bit)
    localparam logic [1:0] MODE_RAW    = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_SIXBIT = 2'd2;

    // register indexes
    localparam logic REG_LINE_MODE   = 1'b0;
    localparam logic REG_CHAR_OFFSET = 1'b1;

    // reset values
    localparam logic [1:0] LINE_MODE_RST   = MODE_SIXBIT;
    localparam logic [7:0] CHAR_OFFSET_RST = 8'd32;

    // characters one input byte can give at most
    localparam int unsigned BURST_DEPTH = 5;
    localparam int unsigned BURST_CW    = $clog2(BURST_DEPTH + 1);

    typedef struct packed {
        logic [1:0] line_mode;
        logic [7:0] char_offset;
    } cfg_t;

    typedef struct packed {
        logic [7:0] line_char;
        logic       last_char;
    } char_t;

    // head of the character burst toward the output stage
    typedef struct packed {
        logic  valid;
        char_t item;
    } head_t;

    // six-bit value plus offset, backslash swapped for brace
    function automatic logic [7:0] six_char(input logic [5:0] v, input logic [7:0] off);
        logic [7:0] c;
        begin
            c = {2'b00, v} + off;
            if (c == BSL_CHAR)
            begin
                c = BRACE_CHAR;
            end
            return c;
        end
    endfunction

endpackage

// ----- design/sle_if.sv -----
// valid/ready stream interfaces for packet bytes and line characters

interface sle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface sle_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_char;
    logic       last_char;

    modport source (output valid, output line_char, output last_char, input ready);
    modport sink (input valid, input line_char, input last_char, output ready);
endinterface

// ----- design/sle_cfg.sv -----
// apb configuration registers: line mode and character offset
module sle_cfg
    import sle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg,
    output logic        group_clear
);

    logic [1:0] line_mode_reg;
    logic [7:0] char_offset_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg   <= LINE_MODE_RST;
            char_offset_reg <= CHAR_OFFSET_RST;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_LINE_MODE)
            begin
                line_mode_reg <= pwdata[1:0];
            end
            else
            begin
                char_offset_reg <= pwdata[7:0];
            end
        end
    end

    // a mode write drops any open six-bit group
    assign group_clear = wr_en && (paddr[2] == REG_LINE_MODE);

    // read mux
    always_comb
    begin
        if (paddr[2] == REG_CHAR_OFFSET)
        begin
            prdata = {24'd0, char_offset_reg};
        end
        else
        begin
            prdata = {30'd0, line_mode_reg};
        end
    end

    assign cfg.line_mode   = line_mode_reg;
    assign cfg.char_offset = char_offset_reg;

endmodule

// ----- design/sle_enc.sv -----
// byte encoder: group state and the registered burst of characters per byte
module sle_enc
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       group_clear,
    sle_byte_if.sink   pkt,
    output head_t      head,
    input  logic       head_pop
);

    char_t                 burst_reg [BURST_DEPTH];
    char_t                 burst_next [BURST_DEPTH];
    logic [BURST_CW-1:0]   cnt_reg;
    logic [BURST_CW-1:0]   cnt_next;
    logic [15:0]           held_bytes_reg;
    logic [15:0]           held_bytes_next;
    logic [1:0]            group_count_reg;
    logic [1:0]            group_count_next;

    char_t                 gen [BURST_DEPTH];
    logic [BURST_CW-1:0]   gen_cnt;
    logic                  take;
    logic                  six_mode;
    logic                  esc;
    logic                  emit;
    logic [7:0]            g0;
    logic [7:0]            g1;
    logic [7:0]            g2;
    logic [7:0]            b;
    logic                  eop;
    logic [7:0]            off;

    assign b        = pkt.data_byte;
    assign eop      = pkt.end_of_packet;
    assign off      = cfg.char_offset;
    assign six_mode = cfg.line_mode[1];

    // room when the burst is empty or its last character leaves now
    assign pkt.ready = (cnt_reg == '0) || ((cnt_reg == BURST_CW'(1)) && head_pop);
    assign take      = pkt.valid && pkt.ready;

    // six-bit group bytes, open group padded with zeros
    always_comb
    begin
        g0 = (group_count_reg == 2'd0) ? b : held_bytes_reg[7:0];
        case (group_count_reg)
            2'd0:    g1 = 8'd0;
            2'd1:    g1 = b;
            default: g1 = held_bytes_reg[15:8];
        endcase
        g2 = (group_count_reg == 2'd2) ? b : 8'd0;
    end

    assign esc  = (b == NL_CHAR) || (b == BSL_CHAR);
    assign emit = (group_count_reg == 2'd2) || eop;

    // characters for the current byte
    always_comb
    begin
        for (int i = 0; i < BURST_DEPTH; i++)
        begin
            gen[i] = '{line_char: NL_CHAR, last_char: 1'b1};
        end
        gen_cnt          = '0;
        held_bytes_next  = held_bytes_reg;
        group_count_next = group_count_reg;
        if (six_mode)
        begin
            gen[0].line_char = six_char(g0[5:0], off);
            gen[1].line_char = six_char({g1[3:0], g0[7:6]}, off);
            gen[2].line_char = six_char({g2[1:0], g1[7:4]}, off);
            gen[3].line_char = six_char(g2[7:2], off);
            for (int i = 0; i < 4; i++)
            begin
                gen[i].last_char = 1'b0;
            end
            if (emit)
            begin
                gen_cnt          = eop ? BURST_CW'(5) : BURST_CW'(4);
                held_bytes_next  = '0;
                group_count_next = 2'd0;
            end
            else
            begin
                if (group_count_reg == 2'd0)
                begin
                    held_bytes_next = {8'd0, b};
                end
                else
                begin
                    held_bytes_next = {b, held_bytes_reg[7:0]};
                end
                group_count_next = group_count_reg + 2'd1;
            end
        end
        else if (cfg.line_mode == MODE_ESCAPE)
        begin
            if (esc)
            begin
                gen[0]  = '{line_char: BSL_CHAR, last_char: 1'b0};
                gen[1]  = '{line_char: b, last_char: 1'b0};
                gen_cnt = eop ? BURST_CW'(3) : BURST_CW'(2);
            end
            else
            begin
                gen[0]  = '{line_char: b, last_char: 1'b0};
                gen_cnt = eop ? BURST_CW'(2) : BURST_CW'(1);
            end
        end
        else
        begin
            gen[0]  = '{line_char: b, last_char: eop};
            gen_cnt = BURST_CW'(1);
        end
    end

    // burst load on transfer, shift on pop
    always_comb
    begin
        burst_next = burst_reg;
        cnt_next   = cnt_reg;
        if (take)
        begin
            burst_next = gen;
            cnt_next   = gen_cnt;
        end
        else if (head_pop)
        begin
            for (int i = 0; i < BURST_DEPTH - 1; i++)
            begin
                burst_next[i] = burst_reg[i + 1];
            end
            cnt_next = cnt_reg - BURST_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        burst_reg <= burst_next;
    end

    // control and group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            held_bytes_reg  <= '0;
            group_count_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (group_clear)
            begin
                held_bytes_reg  <= '0;
                group_count_reg <= 2'd0;
            end
            else if (take)
            begin
                held_bytes_reg  <= held_bytes_next;
                group_count_reg <= group_count_next;
            end
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.item  = burst_reg[0];

endmodule

// ----- design/sle_out.sv -----
// output register toward the line
module sle_out
    import sle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  head_t      head,
    output logic       head_pop,
    sle_char_if.source line
);

    logic  valid_reg;
    char_t char_reg;
    logic  load;

    // register is free when empty or its character leaves now
    assign load     = !valid_reg || line.ready;
    assign head_pop = load && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= head.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
        begin
            char_reg <= head.item;
        end
    end

    assign line.valid     = valid_reg;
    assign line.line_char = char_reg.line_char;
    assign line.last_char = char_reg.last_char;

endmodule

// ----- design/serial_line_packet_encoder_top.sv -----
// Serial line packet encoder: packet bytes in, line characters out. Each accepted byte is
// turned into 0 to 5 characters held in a burst register, which drains one character per
// cycle, while the line is ready, through the output register; the next byte is taken
// when the burst is empty or in the cycle the last of its characters leaves, so bytes that
// give one character or none flow at one per cycle while the line is ready. A character
// passes from the burst register through the output register to the line. Registers: line
// mode at byte address 0 (0 raw, 1 escape framing, 2 or 3 six-bit packing; a write drops
// an open six-bit group) and character offset at address 4. Write them only while idle.
module serial_line_packet_encoder_top
    import sle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sle_byte_if.sink    pkt,
    sle_char_if.source  line
);

    cfg_t  cfg;
    logic  group_clear;
    head_t head;
    logic  head_pop;

    // configuration registers
    sle_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .group_clear (group_clear)
    );

    // byte encoder and burst register
    sle_enc u_enc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .group_clear (group_clear),
        .pkt         (pkt),
        .head        (head),
        .head_pop    (head_pop)
    );

    // output register
    sle_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_pop (head_pop),
        .line     (line)
    );

endmodule
